// ===== rtl/pcc_pkg.sv =====
// ----------------------------------------------------------------------------
// pcc_pkg
// shared types, constants and helper functions of the post class classifier
// ----------------------------------------------------------------------------
package pcc_pkg;

  localparam int MAX_VARS  = 6;
  localparam int TT_WIDTH  = 64;
  localparam int K_WIDTH   = 3;
  localparam int NUM_CLS   = 5;
  localparam int VAR_COUNT = 6;

  // bit positions inside a class vector
  localparam int CLS_ZERO = 0;
  localparam int CLS_ONE  = 1;
  localparam int CLS_SD   = 2;
  localparam int CLS_MONO = 3;
  localparam int CLS_LIN  = 4;

  typedef logic [NUM_CLS-1:0]  class_vec_t;
  typedef logic [TT_WIDTH-1:0] table_t;
  typedef logic [K_WIDTH-1:0]  nvars_t;

  // table positions whose variable-v bit is clear
  function automatic table_t var_clear_mask(input int v);
    table_t m;
    m = '0;
    for (int j = 0; j < TT_WIDTH; j++) begin
      m[j] = ((j >> v) & 1) == 0;
    end
    return m;
  endfunction

  // positions of ANF terms that hold two or more variables
  function automatic table_t multi_var_mask();
    table_t m;
    logic [VAR_COUNT-1:0] idx;
    m = '0;
    for (int j = 0; j < TT_WIDTH; j++) begin
      idx  = VAR_COUNT'(j);
      m[j] = $countones(idx) >= 2;
    end
    return m;
  endfunction

  // live table bits for a given variable count
  function automatic table_t live_mask(input nvars_t k);
    table_t m;
    m = '0;
    for (int j = 0; j < TT_WIDTH; j++) begin
      m[j] = j < (1 << k);
    end
    return m;
  endfunction

endpackage

// ===== rtl/post_class_classifier.sv =====
// ----------------------------------------------------------------------------
// post_class_classifier
// sorts boolean functions into the five post classes and flags complete sets
// ----------------------------------------------------------------------------
// Each input item is one boolean function of num_vars variables (0 to 6),
// given as a 64-bit truth table of which only the low 2^num_vars bits count;
// a larger num_vars is taken as 6. For every item one result item reports
// whether the function preserves zero, preserves one, is self-dual, is
// monotone and is linear (read from the algebraic normal form). Five sticky
// flags track whether every function of the current set lies in each class;
// set_complete is 1 when none is left set, and is the verdict on the item
// marked last_in_set, after which the flags return to all ones. The block
// is a two-register pipeline: an input register and a result register with
// the classification logic between them. It takes one item per clock cycle
// while the result side does not stall; an accepted item waits in the input
// register until the result register frees, updating the sticky flags.
// ----------------------------------------------------------------------------
module post_class_classifier (
  input  logic                    clk,
  input  logic                    rst,
  // input channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  pcc_pkg::table_t         truth_table,
  input  pcc_pkg::nvars_t         num_vars,
  input  logic                    last_in_set,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    keeps_zero,
  output logic                    keeps_one,
  output logic                    is_self_dual,
  output logic                    is_monotone,
  output logic                    is_linear,
  output logic                    set_complete,
  output logic                    last_out
);
  import pcc_pkg::*;

  // input register stage
  logic       s1_valid;
  table_t     s1_tt;
  nvars_t     s1_k;
  logic       s1_last;

  // sticky class flags of the current set
  class_vec_t flags;
  class_vec_t flags_next;

  // classification of the item in the input register
  nvars_t     k_eff;
  table_t     tmask;
  table_t     tt_m;
  table_t     anf;
  class_vec_t classes;
  logic       sd_bit [VAR_COUNT+1];
  logic       one_bit;
  logic       mono;

  logic       s2_free;
  logic       s1_move;

  // a result slot frees when empty or taken this cycle
  assign s2_free  = !out_valid || out_ready;
  assign s1_move  = s1_valid && s2_free;
  assign in_ready = !s1_valid || s2_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_tt   <= truth_table;
      s1_k    <= num_vars;
      s1_last <= last_in_set;
    end
  end

  always_comb begin
    // clamp the variable count and drop bits past the table
    k_eff = (s1_k > K_WIDTH'(MAX_VARS)) ? K_WIDTH'(MAX_VARS) : s1_k;
    tmask = live_mask(k_eff);
    tt_m  = s1_tt & tmask;

    // value at the all-ones input, index 2^k-1
    one_bit = 1'b0;
    for (int kk = 0; kk <= VAR_COUNT; kk++) begin
      if (k_eff == K_WIDTH'(kk)) begin
        one_bit = tt_m[(1 << kk) - 1];
      end
    end

    // self-dual: each value differs from its complement index, per table size
    for (int kk = 0; kk <= VAR_COUNT; kk++) begin
      sd_bit[kk] = 1'b1;
      for (int j = 0; j < (1 << kk); j++) begin
        if (tt_m[j] == tt_m[(1 << kk) - 1 - j]) begin
          sd_bit[kk] = 1'b0;
        end
      end
    end

    // monotone by neighbour pairs, anf by moebius butterflies
    mono = 1'b1;
    anf  = tt_m;
    for (int v = 0; v < VAR_COUNT; v++) begin
      if (K_WIDTH'(v) < k_eff) begin
        if (((tt_m & var_clear_mask(v)) & ~((tt_m >> (1 << v)) & var_clear_mask(v))
             & tmask) != '0) begin
          mono = 1'b0;
        end
        anf = anf ^ ((anf & var_clear_mask(v)) << (1 << v));
      end
    end
    anf = anf & tmask;

    classes           = '0;
    classes[CLS_ZERO] = !tt_m[0];
    classes[CLS_ONE]  = one_bit;
    classes[CLS_SD]   = 1'b0;
    for (int kk = 0; kk <= VAR_COUNT; kk++) begin
      if (k_eff == K_WIDTH'(kk)) begin
        classes[CLS_SD] = sd_bit[kk];
      end
    end
    classes[CLS_MONO] = mono;
    classes[CLS_LIN]  = (anf & multi_var_mask()) == '0;

    flags_next = flags & classes;
  end

  // result register and sticky flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      flags     <= '1;
    end else begin
      if (s2_free) begin
        out_valid <= s1_valid;
      end
      if (s1_move) begin
        // end of set re-arms every class
        flags <= s1_last ? '1 : flags_next;
      end
    end
    if (s1_move) begin
      keeps_zero   <= classes[CLS_ZERO];
      keeps_one    <= classes[CLS_ONE];
      is_self_dual <= classes[CLS_SD];
      is_monotone  <= classes[CLS_MONO];
      is_linear    <= classes[CLS_LIN];
      set_complete <= flags_next == '0;
      last_out     <= s1_last;
    end
  end

  // a self-dual function maps all-zero and all-one inputs to opposite values
  a_sd_ends : assert property (@(posedge clk) disable iff (rst)
    out_valid && is_self_dual |-> keeps_zero == keeps_one)
    else $error("self-dual result with mismatched end values");

  // the flags are re-armed after the last item of a set
  a_rearm : assert property (@(posedge clk) disable iff (rst)
    s1_move && s1_last |=> flags == '1)
    else $error("class flags not re-armed after end of set");

  // a complete verdict mid-set leaves every flag clear
  a_clear : assert property (@(posedge clk) disable iff (rst)
    s1_move && !s1_last && flags_next == '0 |=> flags == '0 && set_complete)
    else $error("class flags inconsistent with set_complete");

endmodule

// ===== sim/tb_post_class_classifier.sv =====
// ----------------------------------------------------------------------------
// tb_post_class_classifier
// self-checking testbench for the post class classifier
// ----------------------------------------------------------------------------
// Boolean functions are pushed through the input channel and the five class
// bits, the set verdict and the last marker of every result are checked
// against a local predictor, which keeps its own copy of the sticky
// class flags. Both channels idle and stall in random bursts, except in
// the closing part, which runs back to back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_post_class_classifier;
  import pcc_pkg::*;

  // expected content of one result item
  typedef struct packed {
    logic keeps_zero;
    logic keeps_one;
    logic self_dual;
    logic monotone;
    logic linear;
    logic complete;
    logic last;
  } verdict_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_ready;
  table_t truth_table = '0;
  nvars_t num_vars = '0;
  logic   last_in_set = 1'b0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  logic   keeps_zero;
  logic   keeps_one;
  logic   is_self_dual;
  logic   is_monotone;
  logic   is_linear;
  logic   set_complete;
  logic   last_out;

  // predictor state: sticky class flags of the current set
  class_vec_t set_flags = '1;
  // verdicts waiting for their result item, oldest first
  verdict_t   pending_verdicts[$];
  int         mismatches = 0;
  // cleared in the closing part so that both sides run at full rate
  logic       allow_idle = 1'b1;
  int         ready_stall = 0;

  post_class_classifier uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .truth_table  (truth_table),
    .num_vars     (num_vars),
    .last_in_set  (last_in_set),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .keeps_zero   (keeps_zero),
    .keeps_one    (keeps_one),
    .is_self_dual (is_self_dual),
    .is_monotone  (is_monotone),
    .is_linear    (is_linear),
    .set_complete (set_complete),
    .last_out     (last_out)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // classify one function and fold it into the sticky flags
  function automatic verdict_t classify_function(table_t tt_in, nvars_t k_in, logic last);
    int         k;
    int         size;
    table_t     tt;
    table_t     anf;
    class_vec_t cls;
    verdict_t   v_out;
    k = (k_in > MAX_VARS) ? MAX_VARS : int'(k_in);
    size = 1 << k;
    // bits at and above 2^k do not belong to the function
    tt = '0;
    for (int j = 0; j < size; j++) tt[j] = tt_in[j];
    cls = '1;
    cls[CLS_ZERO] = !tt[0];
    cls[CLS_ONE]  = tt[size-1];
    // self-dual: every value differs from the one at the complement index
    for (int j = 0; j < size; j++) begin
      if (tt[j] == tt[size-1-j]) cls[CLS_SD] = 1'b0;
    end
    // monotone: no neighbour pair along any variable goes from 1 down to 0
    for (int v = 0; v < k; v++) begin
      for (int j = 0; j < size; j++) begin
        if (((j >> v) & 1) == 0 && tt[j] && !tt[j + (1 << v)]) cls[CLS_MONO] = 1'b0;
      end
    end
    // moebius transform, one variable at a time
    anf = tt;
    for (int v = 0; v < k; v++) begin
      for (int j = 0; j < size; j++) begin
        if (((j >> v) & 1) == 1) anf[j] = anf[j] ^ anf[j - (1 << v)];
      end
    end
    // linear: no anf term of two or more variables
    for (int j = 0; j < size; j++) begin
      if ($countones(6'(j)) >= 2 && anf[j]) cls[CLS_LIN] = 1'b0;
    end
    set_flags = set_flags & cls;
    v_out.keeps_zero = cls[CLS_ZERO];
    v_out.keeps_one  = cls[CLS_ONE];
    v_out.self_dual  = cls[CLS_SD];
    v_out.monotone   = cls[CLS_MONO];
    v_out.linear     = cls[CLS_LIN];
    v_out.complete   = (set_flags == '0);
    v_out.last       = last;
    if (last) set_flags = '1;
    return v_out;
  endfunction

  // random function, biased toward members of the classes so that sets
  // often stay inside one and come out incomplete
  function automatic table_t make_function(nvars_t k_in);
    int     k;
    int     size;
    int     mask;
    table_t t;
    table_t live;
    k = (k_in > MAX_VARS) ? MAX_VARS : int'(k_in);
    size = 1 << k;
    live = (k >= 6) ? '1 : ((64'd1 << size) - 64'd1);
    t = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      1: begin
        // self-dual: upper half mirrors the inverted lower half
        for (int j = 0; j < size / 2; j++) t[size-1-j] = ~t[j];
      end
      2: begin
        // linear: constant term plus a parity of chosen variables
        mask = $urandom_range(0, 63);
        for (int j = 0; j < size; j++) t[j] = t[63] ^ (^(6'(j & mask)));
      end
      3: begin
        // monotone: upward closure of a random set
        for (int v = 0; v < k; v++) begin
          for (int j = 0; j < size; j++) begin
            if (((j >> v) & 1) == 1) t[j] = t[j] | t[j - (1 << v)];
          end
        end
      end
      default: ;
    endcase
    // sometimes pin the corner values so the preserving classes show up
    if ($urandom_range(0, 3) == 0) t[0] = 1'b0;
    if ($urandom_range(0, 3) == 0) t[size-1] = 1'b1;
    // half of the time the unused bits carry junk
    if ($urandom_range(0, 1) == 0) t = t & live;
    else t = (t & live) | ({$urandom, $urandom} & ~live);
    return t;
  endfunction

  // variable count weighted toward small tables, with the odd oversize one
  function automatic nvars_t pick_vars();
    case ($urandom_range(0, 9))
      0:       return nvars_t'(0);
      1:       return nvars_t'(1);
      2, 3:    return nvars_t'(2);
      4, 5:    return nvars_t'(3);
      6:       return nvars_t'(4);
      7:       return nvars_t'(5);
      8:       return nvars_t'(6);
      default: return nvars_t'(7);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic want, input logic got);
    mismatches++;
    $display("mismatch at %0t: %s expected %0b got %0b", $realtime, what, want, got);
  endtask

  // present one function and hold it until the block takes it
  task automatic send_function(input table_t tt, input nvars_t k, input logic last);
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    truth_table <= tt;
    num_vars    <= k;
    last_in_set <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // taken at this edge
    pending_verdicts.push_back(classify_function(tt, k, last));
  endtask

  // result side: stalls in bursts of random length
  always @(posedge clk) begin
    if (ready_stall > 0) begin
      ready_stall <= ready_stall - 1;
      out_ready   <= 1'b0;
    end else if (allow_idle && $urandom_range(0, 3) == 0) begin
      ready_stall <= $urandom_range(0, 4);
      out_ready   <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare every accepted result with the oldest waiting verdict
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        // a result item arrived with nothing expected
        report_mismatch("out_valid", 1'b0, out_valid);
      end else begin
        want = pending_verdicts.pop_front();
        if (keeps_zero !== want.keeps_zero)
          report_mismatch("keeps_zero", want.keeps_zero, keeps_zero);
        if (keeps_one !== want.keeps_one)
          report_mismatch("keeps_one", want.keeps_one, keeps_one);
        if (is_self_dual !== want.self_dual)
          report_mismatch("is_self_dual", want.self_dual, is_self_dual);
        if (is_monotone !== want.monotone)
          report_mismatch("is_monotone", want.monotone, is_monotone);
        if (is_linear !== want.linear)
          report_mismatch("is_linear", want.linear, is_linear);
        if (set_complete !== want.complete)
          report_mismatch("set_complete", want.complete, set_complete);
        if (last_out !== want.last)
          report_mismatch("last_out", want.last, last_out);
      end
    end
  end

  // zero-variable constants, with and without junk above bit 0
  task automatic test_constants();
    send_function(64'h0, 3'd0, 1'b1);
    send_function(64'h1, 3'd0, 1'b1);
    send_function(64'hFFFF_FFFF_FFFF_FFFE, 3'd0, 1'b0);
    send_function(64'hFFFF_FFFF_FFFF_FFFF, 3'd0, 1'b1);
  endtask

  // extreme tables and variable counts, oversize count included
  task automatic test_extremes();
    send_function(64'h0, 3'd6, 1'b0);
    send_function(64'hFFFF_FFFF_FFFF_FFFF, 3'd6, 1'b1);
    send_function(64'hAAAA_AAAA_AAAA_AAAA, 3'd6, 1'b1);  // projection of x0
    send_function(64'h5555_5555_5555_5555, 3'd7, 1'b1);  // not x0, count clamped
    send_function(64'h6996_9669_9669_6996, 3'd6, 1'b1);  // parity of all six
    send_function(64'h8000_0000_0000_0000, 3'd7, 1'b1);  // and of all six
    send_function(64'h2, 3'd1, 1'b0);                    // identity
    send_function(64'hFFFF_FFFF_FFFF_FFF1, 3'd1, 1'b1);  // negation, junk above
    send_function(64'hE8, 3'd3, 1'b1);                   // majority: sd and monotone
  endtask

  // well-known complete and incomplete sets
  task automatic test_known_sets();
    send_function(64'h7, 3'd2, 1'b1);   // nand alone is complete
    send_function(64'h1, 3'd2, 1'b1);   // nor alone is complete
    send_function(64'h8, 3'd2, 1'b0);   // and, or: monotone and both constant-preserving classes
    send_function(64'hE, 3'd2, 1'b1);
    send_function(64'h8, 3'd2, 1'b0);   // and, not: complete
    send_function(64'h1, 3'd1, 1'b1);
    send_function(64'h6, 3'd2, 1'b0);   // xor, constant 1: linear only
    send_function(64'h1, 3'd0, 1'b1);
    send_function(64'hB, 3'd2, 1'b0);   // implication, constant 0: complete
    send_function(64'h0, 3'd0, 1'b1);
  endtask

  // random sets of random length, each closed by its last item
  task automatic test_random_sets(input int item_target);
    int sent;
    int set_len;
    nvars_t k;
    sent = 0;
    while (sent < item_target) begin
      set_len = $urandom_range(1, 8);
      for (int i = 0; i < set_len; i++) begin
        k = pick_vars();
        send_function(make_function(k), k, i == set_len - 1);
        sent++;
      end
    end
  endtask

  // closing part: no gaps on either side
  task automatic test_full_rate();
    nvars_t k;
    allow_idle = 1'b0;
    for (int i = 0; i < 40; i++) begin
      k = pick_vars();
      send_function(make_function(k), k, (i % 5 == 4) || (i == 39));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_constants();
    test_extremes();
    test_known_sets();
    test_random_sets(490);
    test_full_rate();

    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    // wait on to catch any stray result item
    repeat (10) @(posedge clk);

    if (pending_verdicts.size() != 0)
      report_mismatch("outstanding result items", 1'b0, 1'b1);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pcc_pkg.sv
rtl/post_class_classifier.sv
sim/tb_post_class_classifier.sv
